[src/lts_pkg.sv]
// shared types and constants for the link transmit scheduler
// used by lts_front, lts_jobq, lts_back and link_transmit_scheduler
package lts_pkg;

  localparam int TAG_W   = 16;
  localparam int SIZE_W  = 32;
  localparam int TIME_W  = 48;
  localparam int BW_W    = 32;
  localparam int LAT_W   = 32;
  localparam int FRAC_W  = 8;

  // dividend is size << 8, one quotient bit per step
  localparam int DVD_W     = SIZE_W + FRAC_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // input kinds
  localparam logic FUNC_SEND = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  // result outcomes
  localparam logic [1:0] OUT_STARTED = 2'd0;
  localparam logic [1:0] OUT_QUEUED  = 2'd1;
  localparam logic [1:0] OUT_DROPPED = 2'd2;
  localparam logic [1:0] OUT_IDLE    = 2'd3;

  // configuration register indexes
  localparam logic CFG_BANDWIDTH = 1'b0;
  localparam logic CFG_LATENCY   = 1'b1;

  localparam logic [BW_W-1:0] BW_RESET = 32'd256;

  // work handed from the front to the back
  typedef struct packed {
    logic              start;
    logic [1:0]        outcome;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic [TIME_W-1:0] now;
  } job_t;

  // push side of the job queue
  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

[src/lts_front.sv]
// front part: accepts requests, tracks link busy and the pending chunk ring
// depends on lts_pkg
module lts_front #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic                     in_func,
  input  logic [lts_pkg::TAG_W-1:0]  in_tag,
  input  logic [lts_pkg::SIZE_W-1:0] in_size,
  input  logic [lts_pkg::TIME_W-1:0] in_now,
  input  logic                     push_ready,
  output lts_pkg::job_push_t       push
);
  import lts_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENT_W = TAG_W + SIZE_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [ENT_W-1:0] mem [QUEUE_DEPTH];

  logic              busy_r, busy_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [ENT_W-1:0]  rd_data_r;
  logic [TIME_W-1:0] rd_now_r;

  logic acc, wr_en, rd_en;

  assign in_tready = !rd_pend_r && push_ready;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    busy_nxt    = busy_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    rd_pend_nxt = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    push.valid       = 1'b0;
    push.job.start   = 1'b0;
    push.job.outcome = OUT_IDLE;
    push.job.tag     = '0;
    push.job.size    = '0;
    push.job.now     = '0;
    if (rd_pend_r) begin
      // oldest pending chunk is now out of the ring
      push.valid       = 1'b1;
      push.job.start   = 1'b1;
      push.job.outcome = OUT_STARTED;
      push.job.tag     = rd_data_r[ENT_W-1:SIZE_W];
      push.job.size    = rd_data_r[SIZE_W-1:0];
      push.job.now     = rd_now_r;
    end else if (acc) begin
      if (in_func == FUNC_SEND) begin
        push.valid = 1'b1;
        if (!busy_r) begin
          busy_nxt         = 1'b1;
          push.job.start   = 1'b1;
          push.job.outcome = OUT_STARTED;
          push.job.tag     = in_tag;
          push.job.size    = in_size;
          push.job.now     = in_now;
        end else if (count_r >= CNT_FULL) begin
          push.job.outcome = OUT_DROPPED;
        end else begin
          wr_en            = 1'b1;
          tail_nxt         = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
          count_nxt        = count_r + 1'b1;
          push.job.outcome = OUT_QUEUED;
        end
      end else begin
        if (count_r != '0) begin
          // link frees and the head chunk starts right away
          busy_nxt    = 1'b1;
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          head_nxt    = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
          count_nxt   = count_r - 1'b1;
        end else begin
          busy_nxt         = 1'b0;
          push.valid       = 1'b1;
          push.job.outcome = OUT_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= {in_tag, in_size};
    end
    if (rd_en) begin
      rd_data_r <= mem[head_r];
      rd_now_r  <= in_now;
    end
  end

endmodule

[src/lts_jobq.sv]
// two-entry queue of jobs between the front and the back
// depends on lts_pkg
module lts_jobq (
  input  logic               clk,
  input  logic               rst_n,
  input  lts_pkg::job_push_t push,
  output logic               push_ready,
  output logic               pop_valid,
  output lts_pkg::job_t      pop_job,
  input  logic               pop
);
  import lts_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = ent_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

[src/lts_back.sv]
// back part: serialization delay divider, time sums with saturation, result register
// depends on lts_pkg
module lts_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  input  lts_pkg::job_t              job,
  output logic                       job_pop,
  input  logic [lts_pkg::BW_W-1:0]   bandwidth_q8,
  input  logic [lts_pkg::LAT_W-1:0]  link_latency,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [1:0]                 out_outcome,
  output logic [lts_pkg::TAG_W-1:0]  out_tag,
  output logic [lts_pkg::TIME_W-1:0] out_arrival,
  output logic [lts_pkg::TIME_W-1:0] out_free
);
  import lts_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [1:0]        outcome_r;
  logic [TAG_W-1:0]  tag_out_r;
  logic [TIME_W-1:0] arr_r, free_r;

  // datapath
  logic [DVD_W-1:0]  dvd_r;
  logic [BW_W-1:0]   rem_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W:0]   nl_r;
  logic [TAG_W-1:0]  tag_r;
  logic              bw_zero_r;

  logic              slot_free;
  logic              load_plain, load_start;
  logic [BW_W+1:0]   trial;
  logic              ge;
  logic [BW_W-1:0]   rem_nxt;
  logic [DVD_W-1:0]  dvd_nxt;
  logic [TIME_W-1:0] ser;
  logic [TIME_W:0]   free_sum;
  logic [TIME_W+1:0] arr_sum;
  logic [TIME_W-1:0] free_sat, arr_sat;

  assign slot_free  = !out_valid_r || out_tready;
  assign job_pop    = (state_r == ST_IDLE) && job_valid && (job.start || slot_free);
  assign load_plain = job_pop && !job.start;
  assign load_start = (state_r == ST_FIN) && slot_free;

  // one restoring step: quotient bits shift into the dividend register
  always_comb begin
    trial   = {1'b0, rem_r, dvd_r[DVD_W-1]} - {2'b00, bandwidth_q8};
    ge      = !trial[BW_W+1];
    rem_nxt = ge ? trial[BW_W-1:0] : {rem_r[BW_W-2:0], dvd_r[DVD_W-1]};
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
  end

  always_comb begin
    ser      = bw_zero_r ? TIME_MAX : {{(TIME_W - DVD_W){1'b0}}, dvd_r};
    free_sum = {1'b0, now_r} + {1'b0, ser};
    arr_sum  = {1'b0, nl_r} + {2'b00, ser};
    free_sat = free_sum[TIME_W] ? TIME_MAX : free_sum[TIME_W-1:0];
    arr_sat  = (arr_sum[TIME_W+1:TIME_W] != 2'b00) ? TIME_MAX : arr_sum[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_plain || load_start) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_pop) begin
            if (job.start) begin
              step_r  <= '0;
              state_r <= (bandwidth_q8 == '0) ? ST_FIN : ST_DIV;
            end else begin
              outcome_r   <= job.outcome;
              tag_out_r   <= '0;
              arr_r       <= '0;
              free_r      <= '0;
            end
          end
        end
        ST_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (slot_free) begin
            outcome_r   <= OUT_STARTED;
            tag_out_r   <= tag_r;
            arr_r       <= arr_sat;
            free_r      <= free_sat;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop && job.start) begin
      dvd_r     <= {job.size, {FRAC_W{1'b0}}};
      rem_r     <= '0;
      now_r     <= job.now;
      nl_r      <= {1'b0, job.now} + {{(TIME_W + 1 - LAT_W){1'b0}}, link_latency};
      tag_r     <= job.tag;
      bw_zero_r <= (bandwidth_q8 == '0);
    end else if (state_r == ST_DIV) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_outcome = outcome_r;
  assign out_tag     = tag_out_r;
  assign out_arrival = arr_r;
  assign out_free    = free_r;

endmodule

[src/link_transmit_scheduler.sv]
// top level of the link transmit scheduler: config registers, front, job queue, back
// depends on lts_pkg, lts_front, lts_jobq, lts_back
// usage
//   in_* is a stream of requests: in_tuser is the kind (0 send a chunk, 1 the link
//   became free), in_tdata carries the chunk tag, chunk size and current time.
//   every request yields exactly one result on out_*: out_tuser holds the outcome
//   (started, queued, dropped on a full queue, idle), out_tdata the started tag
//   with its arrival and link-free times, all zero when nothing started.
//   cfg_* writes bandwidth (index 0, bytes per time unit with 8 fraction bits)
//   and propagation delay (index 1); write only while no request is in flight.
// timing
//   a request that starts a chunk has its result taken after the job queue, setup,
//   a radix-2 divider that yields one quotient bit per cycle, and a finish step;
//   zero bandwidth skips the divide. a request that starts nothing passes from
//   the job queue straight to the result register; a free request with chunks
//   pending first reads the pending chunk memory. the front keeps accepting while
//   the back divides, until the two-entry job queue is full, so the sustained
//   rate is set by the divider.
// reset and stall
//   after reset the link is idle, no chunks are pending, bandwidth is 256 and
//   latency is 0. when out_tready is low the result register holds, the back
//   stops once it has a new result ready and in_tready drops when the job queue fills.
module link_transmit_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // request channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // chunk_tag[15:0], chunk_len[47:16], now_time[95:48]
  input  logic         in_tuser,   // func
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // started_tag[15:0], arrival_time[63:16], free_time[111:64]
  output logic [1:0]   out_tuser,  // outcome
  // configuration writes
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [31:0]  cfg_wdata
);
  import lts_pkg::*;

  logic [BW_W-1:0]  bandwidth_q8_r;
  logic [LAT_W-1:0] link_latency_r;

  job_push_t         push;
  logic              push_ready;
  logic              job_valid;
  job_t              job;
  logic              job_pop;
  logic [TAG_W-1:0]  out_tag;
  logic [TIME_W-1:0] out_arrival, out_free;

  // configuration registers, to be written only while the block is idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bandwidth_q8_r <= BW_RESET;
      link_latency_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BANDWIDTH: bandwidth_q8_r <= cfg_wdata;
        CFG_LATENCY:   link_latency_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // front: classifies each request against busy flag and pending ring
  lts_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_func    (in_tuser),
    .in_tag     (in_tdata[15:0]),
    .in_size    (in_tdata[47:16]),
    .in_now     (in_tdata[95:48]),
    .push_ready (push_ready),
    .push       (push)
  );

  // decouples classification from the long divide
  lts_jobq u_jobq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (job_valid),
    .pop_job    (job),
    .pop        (job_pop)
  );

  // back: delay computation and result register
  lts_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job          (job),
    .job_pop      (job_pop),
    .bandwidth_q8 (bandwidth_q8_r),
    .link_latency (link_latency_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_outcome  (out_tuser),
    .out_tag      (out_tag),
    .out_arrival  (out_arrival),
    .out_free     (out_free)
  );

  assign out_tdata = {out_free, out_arrival, out_tag};

endmodule
